// ===== hdl/dpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Directed Euler path finder package
// Sizes, field widths, command and status codes shared by the block.
// ----------------------------------------------------------------------------
package dpf_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int MAX_EDGES   = 2048;
	localparam int STACK_DEPTH = MAX_EDGES + 1;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int EDGE_W  = $clog2(MAX_EDGES);
	localparam int PTR_W   = $clog2(STACK_DEPTH + 1);
	localparam int HEAD_W  = EDGE_W + 1;
	localparam int BAL_W   = EDGE_W + 2;

	localparam int KIND_W  = 2;
	localparam int NFIELD_W = 11;
	localparam int IDX_W   = 12;
	localparam int STAT_W  = 3;
	localparam int LEN_W   = 12;

	localparam logic [HEAD_W-1:0] NO_EDGE = HEAD_W'(MAX_EDGES);

	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	localparam logic [STAT_W-1:0] ST_TAKEN    = 3'd0;
	localparam logic [STAT_W-1:0] ST_REJECTED = 3'd1;
	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NONE     = 3'd3;
	localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_READ = 3'd5;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  path_length;
		logic [NFIELD_W-1:0] node;
		logic              is_last;
	} result_t;

endpackage

// ===== hdl/dpf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/directed_euler_path_finder.sv =====
// ----------------------------------------------------------------------------
// Directed Euler path finder
// Loads directed edges, checks degrees and runs a stack-based Hierholzer walk
// from node one, then serves the found path entry by entry.
// ----------------------------------------------------------------------------
// Channel  | Dir | Contents
// s_*      | in  | tuser kind, tdata from_node, to_node, path_index
// m_*      | out | tuser status, tdata path_length, node, tlast is_last
// APB      | in  | node_count at byte address 0
//
// An edge add steps through S_A_RD1, S_A_WR1, S_A_RD2 and S_A_WR2, a read
// via S_R_RD and S_R_OUT; a rejected edge or bad read replies from S_IDLE.
// Clear and the pass after reset sweep the 1024 node entries, one per cycle.
// Solve sweeps the node entries, then walks the edges through the cursor and
// stack RAMs, each push or pop via S_W_CUR, S_W_EDGE and S_W_PUSH or S_W_POP.
// s_tready stays low while an item is at work or its result waits on m_*.
// ----------------------------------------------------------------------------
module directed_euler_path_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // from_node[10:0], to_node[21:11], path_index[33:22]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // path_length[11:0], node[22:12]
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_A_RD1  = 4'd2;
	localparam logic [3:0] S_A_WR1  = 4'd3;
	localparam logic [3:0] S_A_RD2  = 4'd4;
	localparam logic [3:0] S_A_WR2  = 4'd5;
	localparam logic [3:0] S_CHK    = 4'd6;
	localparam logic [3:0] S_W_CUR  = 4'd7;
	localparam logic [3:0] S_W_EDGE = 4'd8;
	localparam logic [3:0] S_W_PUSH = 4'd9;
	localparam logic [3:0] S_W_POP  = 4'd10;
	localparam logic [3:0] S_W_DONE = 4'd11;
	localparam logic [3:0] S_R_RD   = 4'd12;
	localparam logic [3:0] S_R_OUT  = 4'd13;

	localparam int NW = dpf_pkg::NODE_W;
	localparam int EW = dpf_pkg::EDGE_W;
	localparam int PW = dpf_pkg::PTR_W;
	localparam int HW = dpf_pkg::HEAD_W;
	localparam int BW = dpf_pkg::BAL_W;
	localparam int FW = dpf_pkg::NFIELD_W;
	localparam int LW = dpf_pkg::LEN_W;

	logic [3:0]    state_q;
	logic [FW-1:0] node_count_q;
	logic [LW-1:0] edge_total_q;
	logic [LW-1:0] path_count_q;
	logic [FW-1:0] from_q, to_q;
	logic [dpf_pkg::IDX_W-1:0] idx_q;
	logic [NW:0]   cnt_q;
	logic          clr_reply_q;
	logic          chk_v_s1;
	logic [NW-1:0] chk_i_s1;
	logic [1:0]    plus_q, minus_q;
	logic          bad_q;
	logic [PW-1:0] sp_q, pc_q;
	logic [NW-1:0] top_q, first_q, last_q;
	logic          m_tvalid_q;
	dpf_pkg::result_t res_q;

	logic [FW-1:0] n_eff;
	logic [FW-1:0] s_from, s_to;
	logic [dpf_pkg::IDX_W-1:0] s_idx;
	logic          add_ok;
	logic          accept;
	logic [dpf_pkg::STAT_W-1:0] acc_status;

	logic          bal_we, head_we, cur_we, dest_we, next_we, stk_we, path_we;
	logic [NW-1:0] bal_wa, head_wa, cur_wa, bal_ra, head_ra, cur_ra;
	logic [BW-1:0] bal_wd, bal_rd;
	logic [HW-1:0] head_wd, head_rd, cur_wd, cur_rd, next_wd, next_rd;
	logic [EW-1:0] edge_wa, edge_ra;
	logic [NW-1:0] dest_wd, dest_rd, stk_wd, stk_rd, path_wd, path_rd;
	logic [PW-1:0] stk_wa, stk_ra, path_wa, path_ra;

	assign n_eff  = (node_count_q > FW'(dpf_pkg::MAX_NODES)) ? FW'(dpf_pkg::MAX_NODES)
	                                                         : node_count_q;
	assign s_from = s_tdata[10:0];
	assign s_to   = s_tdata[21:11];
	assign s_idx  = s_tdata[33:22];
	assign add_ok = (s_from != '0) && (s_to != '0) && (s_from <= n_eff) &&
	                (s_to <= n_eff) && (edge_total_q < LW'(dpf_pkg::MAX_EDGES));

	assign s_tready = (state_q == S_IDLE) && !m_tvalid_q;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {1'b0, res_q.node, res_q.path_length};
	assign m_tlast  = res_q.is_last;

	assign pready = 1'b1;
	assign prdata = {21'd0, node_count_q};

	always_comb begin
		acc_status = dpf_pkg::ST_TAKEN;
		if (s_tuser == dpf_pkg::KIND_ADD && !add_ok) begin
			acc_status = dpf_pkg::ST_REJECTED;
		end else if (s_tuser == dpf_pkg::KIND_READ && !(s_idx < path_count_q)) begin
			acc_status = dpf_pkg::ST_BAD_READ;
		end
	end

	always_comb begin
		bal_we  = 1'b0;
		head_we = 1'b0;
		cur_we  = 1'b0;
		dest_we = 1'b0;
		next_we = 1'b0;
		stk_we  = 1'b0;
		path_we = 1'b0;
		bal_wa  = cnt_q[NW-1:0];
		bal_wd  = '0;
		head_wa = cnt_q[NW-1:0];
		head_wd = dpf_pkg::NO_EDGE;
		cur_wa  = chk_i_s1;
		cur_wd  = head_rd;
		edge_wa = edge_total_q[EW-1:0];
		dest_wd = NW'(to_q - FW'(1));
		next_wd = head_rd;
		stk_wa  = sp_q;
		stk_wd  = dest_rd;
		path_wa = pc_q;
		path_wd = top_q;
		bal_ra  = NW'(from_q - FW'(1));
		head_ra = NW'(from_q - FW'(1));
		cur_ra  = top_q;
		edge_ra = cur_rd[EW-1:0];
		stk_ra  = PW'(sp_q - PW'(2));
		path_ra = PW'(path_count_q - LW'(1) - idx_q);
		case (state_q)
			S_CLR: begin
				bal_we  = !cnt_q[NW];
				head_we = !cnt_q[NW];
			end
			S_A_WR1: begin
				bal_we  = 1'b1;
				bal_wd  = BW'(bal_rd - BW'(1));
				bal_wa  = NW'(from_q - FW'(1));
				head_we = 1'b1;
				head_wa = NW'(from_q - FW'(1));
				head_wd = HW'(edge_total_q);
				dest_we = 1'b1;
				next_we = 1'b1;
			end
			S_A_RD2: begin
				bal_ra = NW'(to_q - FW'(1));
			end
			S_A_WR2: begin
				bal_we = 1'b1;
				bal_wa = NW'(to_q - FW'(1));
				bal_wd = BW'(bal_rd + BW'(1));
			end
			S_CHK: begin
				bal_ra  = cnt_q[NW-1:0];
				head_ra = cnt_q[NW-1:0];
				cur_we  = chk_v_s1;
				if (cnt_q[NW] && !chk_v_s1) begin
					stk_we = 1'b1;
					stk_wa = '0;
					stk_wd = '0;
				end
			end
			S_W_EDGE: begin
				if (!(cur_rd < dpf_pkg::NO_EDGE && sp_q < PW'(dpf_pkg::STACK_DEPTH))) begin
					path_we = pc_q < PW'(dpf_pkg::STACK_DEPTH);
				end
			end
			S_W_PUSH: begin
				cur_we = 1'b1;
				cur_wa = top_q;
				cur_wd = next_rd;
				stk_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			node_count_q <= FW'(1);
			edge_total_q <= '0;
			path_count_q <= '0;
			cnt_q        <= '0;
			clr_reply_q  <= 1'b0;
			chk_v_s1     <= 1'b0;
			m_tvalid_q   <= 1'b0;
			sp_q         <= '0;
			pc_q         <= '0;
		end else begin
			if (psel && penable && pwrite && !paddr[2]) begin
				node_count_q <= pwdata[FW-1:0];
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						from_q <= s_from;
						to_q   <= s_to;
						idx_q  <= s_idx;
						res_q  <= '{status: acc_status, path_length: path_count_q,
						            node: '0, is_last: 1'b0};
						case (s_tuser)
							dpf_pkg::KIND_ADD: begin
								if (add_ok) begin
									state_q <= S_A_RD1;
								end else begin
									m_tvalid_q <= 1'b1;
								end
							end
							dpf_pkg::KIND_SOLVE: begin
								path_count_q <= '0;
								cnt_q        <= '0;
								plus_q       <= '0;
								minus_q      <= '0;
								bad_q        <= 1'b0;
								state_q      <= S_CHK;
							end
							dpf_pkg::KIND_READ: begin
								if (s_idx < path_count_q) begin
									state_q <= S_R_RD;
								end else begin
									m_tvalid_q <= 1'b1;
								end
							end
							default: begin
								cnt_q       <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= S_CLR;
							end
						endcase
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[NW]) begin
						edge_total_q <= '0;
						path_count_q <= '0;
						if (clr_reply_q) begin
							res_q.path_length <= '0;
							m_tvalid_q        <= 1'b1;
						end
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_A_RD1: state_q <= S_A_WR1;
				S_A_WR1: state_q <= S_A_RD2;
				S_A_RD2: state_q <= S_A_WR2;
				S_A_WR2: begin
					edge_total_q <= edge_total_q + 1'b1;
					m_tvalid_q   <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_CHK: begin
					chk_v_s1 <= !cnt_q[NW];
					chk_i_s1 <= cnt_q[NW-1:0];
					if (!cnt_q[NW]) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (chk_v_s1 && ({1'b0, chk_i_s1} < n_eff)) begin
						if (bal_rd == BW'(1)) begin
							plus_q <= (plus_q == 2'd3) ? plus_q : plus_q + 1'b1;
						end else if (bal_rd == {BW{1'b1}}) begin
							minus_q <= (minus_q == 2'd3) ? minus_q : minus_q + 1'b1;
						end else if (bal_rd != '0) begin
							bad_q <= 1'b1;
						end
					end
					if (cnt_q[NW] && !chk_v_s1) begin
						if (n_eff >= FW'(2) && plus_q == 2'd1 && minus_q == 2'd1 && !bad_q) begin
							sp_q    <= PW'(1);
							pc_q    <= '0;
							top_q   <= '0;
							state_q <= S_W_CUR;
						end else begin
							res_q.status      <= dpf_pkg::ST_NONE;
							res_q.path_length <= '0;
							m_tvalid_q        <= 1'b1;
							state_q           <= S_IDLE;
						end
					end
				end
				S_W_CUR: state_q <= S_W_EDGE;
				S_W_EDGE: begin
					if (cur_rd < dpf_pkg::NO_EDGE && sp_q < PW'(dpf_pkg::STACK_DEPTH)) begin
						state_q <= S_W_PUSH;
					end else begin
						if (pc_q < PW'(dpf_pkg::STACK_DEPTH)) begin
							if (pc_q == '0) begin
								first_q <= top_q;
							end
							last_q <= top_q;
							pc_q   <= pc_q + 1'b1;
						end
						sp_q    <= sp_q - 1'b1;
						state_q <= (sp_q == PW'(1)) ? S_W_DONE : S_W_POP;
					end
				end
				S_W_PUSH: begin
					top_q   <= dest_rd;
					sp_q    <= sp_q + 1'b1;
					state_q <= S_W_CUR;
				end
				S_W_POP: begin
					top_q   <= stk_rd;
					state_q <= S_W_CUR;
				end
				S_W_DONE: begin
					if ({1'b0, pc_q} == ({1'b0, edge_total_q} + 13'd1) &&
					    first_q == NW'(n_eff - FW'(1)) && last_q == '0) begin
						path_count_q      <= LW'(pc_q);
						res_q.status      <= dpf_pkg::ST_FOUND;
						res_q.path_length <= LW'(pc_q);
					end else begin
						res_q.status      <= dpf_pkg::ST_NONE;
						res_q.path_length <= '0;
					end
					m_tvalid_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_R_RD: state_q <= S_R_OUT;
				S_R_OUT: begin
					res_q.status  <= dpf_pkg::ST_ENTRY;
					res_q.node    <= FW'(path_rd) + FW'(1);
					res_q.is_last <= (idx_q == path_count_q - LW'(1));
					m_tvalid_q    <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	dpf_ram #(.WIDTH(BW), .DEPTH(dpf_pkg::MAX_NODES)) u_bal (
		.clk(clk), .we(bal_we), .waddr(bal_wa), .wdata(bal_wd), .raddr(bal_ra), .rdata(bal_rd)
	);
	dpf_ram #(.WIDTH(HW), .DEPTH(dpf_pkg::MAX_NODES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
		.rdata(head_rd)
	);
	dpf_ram #(.WIDTH(HW), .DEPTH(dpf_pkg::MAX_NODES)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd)
	);
	dpf_ram #(.WIDTH(NW), .DEPTH(dpf_pkg::MAX_EDGES)) u_dest (
		.clk(clk), .we(dest_we), .waddr(edge_wa), .wdata(dest_wd), .raddr(edge_ra),
		.rdata(dest_rd)
	);
	dpf_ram #(.WIDTH(HW), .DEPTH(dpf_pkg::MAX_EDGES)) u_next (
		.clk(clk), .we(next_we), .waddr(edge_wa), .wdata(next_wd), .raddr(edge_ra),
		.rdata(next_rd)
	);
	dpf_ram #(.WIDTH(NW), .DEPTH(dpf_pkg::STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa[$clog2(dpf_pkg::STACK_DEPTH)-1:0]),
		.wdata(stk_wd), .raddr(stk_ra[$clog2(dpf_pkg::STACK_DEPTH)-1:0]), .rdata(stk_rd)
	);
	dpf_ram #(.WIDTH(NW), .DEPTH(dpf_pkg::STACK_DEPTH)) u_path (
		.clk(clk), .we(path_we), .waddr(path_wa[$clog2(dpf_pkg::STACK_DEPTH)-1:0]),
		.wdata(path_wd), .raddr(path_ra[$clog2(dpf_pkg::STACK_DEPTH)-1:0]), .rdata(path_rd)
	);

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid_q) else $error("ready while a result is pending");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PW'(dpf_pkg::STACK_DEPTH)) else $error("stack pointer out of range");
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PW'(dpf_pkg::STACK_DEPTH)) else $error("path count out of range");
	a_edges_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= LW'(dpf_pkg::MAX_EDGES)) else $error("edge total out of range");
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.status == dpf_pkg::ST_FOUND) |->
		res_q.path_length == edge_total_q + LW'(1)) else $error("found path length mismatch");

endmodule

// ===== dv/dpf_checker.sv =====
// ----------------------------------------------------------------------------
// Directed Euler path finder checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the graph, predicts one result per accepted input beat and compares every
// output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dpf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // from_node[10:0], to_node[21:11], path_index[33:22]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // path_length[11:0], node[22:12]
	input  logic [2:0]  m_tuser,  // status[2:0]
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          pending,
	output int          errors,
	output int          paths_found
);

	localparam int MAXN = dpf_pkg::MAX_NODES;
	localparam int MAXE = dpf_pkg::MAX_EDGES;
	localparam int NFW  = dpf_pkg::NFIELD_W;
	localparam int LENW = dpf_pkg::LEN_W;

	logic [10:0] node_cfg;
	int unsigned arc_total;
	int unsigned path_cnt;
	int unsigned in_deg   [MAXN];
	int unsigned out_deg  [MAXN];
	int unsigned arc_head [MAXN];
	int unsigned walk_cur [MAXN];
	int unsigned arc_to   [MAXE];
	int unsigned arc_link [MAXE];
	int unsigned walk_stk [MAXE + 1];
	int unsigned path_mem [MAXE + 1];
	dpf_pkg::result_t expected_results [$];

	function automatic int unsigned active_nodes();
		return (node_cfg > MAXN) ? MAXN : node_cfg;
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < MAXN; i++) begin
			in_deg[i]   = 0;
			out_deg[i]  = 0;
			arc_head[i] = MAXE;
		end
		arc_total = 0;
		path_cnt  = 0;
	endfunction

	function automatic bit walk_found();
		int unsigned n;
		int unsigned sp;
		int unsigned pc;
		int unsigned bal;
		int unsigned plus;
		int unsigned minus;
		int unsigned u;
		int unsigned a;
		int          d;
		n     = active_nodes();
		sp    = 0;
		pc    = 0;
		bal   = 0;
		plus  = 0;
		minus = 0;
		for (int i = 0; i < n; i++) begin
			d = int'(in_deg[i]) - int'(out_deg[i]);
			if (d == 0) bal++;
			else if (d == 1) plus++;
			else if (d == -1) minus++;
		end
		path_cnt = 0;
		if (!(n >= 2 && bal == n - 2 && plus == 1 && minus == 1))
			return 0;
		for (int i = 0; i < MAXN; i++)
			walk_cur[i] = arc_head[i];
		walk_stk[sp] = 0;
		sp++;
		while (sp > 0) begin
			u = walk_stk[sp - 1];
			a = walk_cur[u];
			if (a < MAXE && sp < MAXE + 1) begin
				walk_cur[u] = arc_link[a];
				walk_stk[sp] = arc_to[a];
				sp++;
			end else begin
				if (pc < MAXE + 1) begin
					path_mem[pc] = u;
					pc++;
				end
				sp--;
			end
		end
		if (pc != arc_total + 1 || path_mem[0] != n - 1 || path_mem[pc - 1] != 0)
			return 0;
		path_cnt = pc;
		return 1;
	endfunction

	function automatic dpf_pkg::result_t predict_result(logic [1:0] kind, logic [10:0] src,
			logic [10:0] dst, logic [11:0] idx);
		dpf_pkg::result_t r;
		int unsigned n;
		n = active_nodes();
		r = '0;
		case (kind)
			dpf_pkg::KIND_ADD: begin
				if (src == 0 || dst == 0 || src > n || dst > n || arc_total >= MAXE) begin
					r.status = dpf_pkg::ST_REJECTED;
				end else begin
					arc_to[arc_total]   = dst - 1;
					arc_link[arc_total] = arc_head[src - 1];
					arc_head[src - 1]   = arc_total;
					out_deg[src - 1]++;
					in_deg[dst - 1]++;
					arc_total++;
					r.status = dpf_pkg::ST_TAKEN;
				end
			end
			dpf_pkg::KIND_SOLVE: begin
				if (walk_found()) begin
					r.status = dpf_pkg::ST_FOUND;
					paths_found++;
				end else begin
					r.status = dpf_pkg::ST_NONE;
				end
			end
			dpf_pkg::KIND_READ: begin
				if (idx < path_cnt) begin
					r.status  = dpf_pkg::ST_ENTRY;
					r.node    = NFW'(path_mem[path_cnt - 1 - idx] + 1);
					r.is_last = (idx == path_cnt - 1);
				end else begin
					r.status = dpf_pkg::ST_BAD_READ;
				end
			end
			default: begin
				wipe_graph();
				r.status = dpf_pkg::ST_TAKEN;
			end
		endcase
		r.path_length = LENW'(path_cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		dpf_pkg::result_t got;
		dpf_pkg::result_t want;
		dpf_pkg::result_t fresh;
		if (!arst_n) begin
			node_cfg    = 11'd1;
			paths_found = 0;
			errors      = 0;
			expected_results.delete();
			wipe_graph();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && !paddr[2])
				node_cfg = pwdata[10:0];
			if (m_tvalid && m_tready) begin
				got.status      = m_tuser;
				got.path_length = m_tdata[11:0];
				got.node        = m_tdata[22:12];
				got.is_last     = m_tlast;
				if (expected_results.size() == 0) begin
					$error("Result beat arrived with no expectation waiting.");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.path_length !== want.path_length) begin
						$error("path_length: expected %0d, got %0d", want.path_length,
							got.path_length);
						errors++;
					end
					if (got.node !== want.node) begin
						$error("node: expected %0d, got %0d", want.node, got.node);
						errors++;
					end
					if (got.is_last !== want.is_last) begin
						$error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				fresh = predict_result(s_tuser, s_tdata[10:0], s_tdata[21:11],
					s_tdata[33:22]);
				expected_results.insert(expected_results.size(), fresh);
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== dv/tb_directed_euler_path_finder.sv =====
// ----------------------------------------------------------------------------
// Directed Euler path finder testbench
// Drives directed cases and random graphs holding an Euler path with noise
// mixed in through the stream and configuration ports, with random stalls on
// both sides. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_directed_euler_path_finder;

	localparam int CYCLE_LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // from_node[10:0], to_node[21:11], path_index[33:22]
	logic [1:0]  s_tuser;  // kind[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // path_length[11:0], node[22:12]
	logic [2:0]  m_tuser;  // status[2:0]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int errors;
	int paths_found;
	int send_idle;
	int recv_idle;
	int beats_sent;
	int cycles = 0;
	int graphs;

	directed_euler_path_finder dut (.*);

	dpf_checker checker_i (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.pending, .errors, .paths_found
	);

	always #4 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic put(logic [1:0] kind, int unsigned src, int unsigned dst,
			int unsigned idx);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, 12'(idx), 11'(dst), 11'(src)};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_nodes(int unsigned n);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'd0;
		pwdata  <= 32'(n);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_graph(int unsigned n);
		int unsigned hops;
		int unsigned stops [$];
		int unsigned src_q [$];
		int unsigned dst_q [$];
		int unsigned j;
		int unsigned t;
		hops = $urandom_range(1, 12);
		stops.insert(stops.size(), 1);
		for (int k = 1; k < hops; k++) stops.insert(stops.size(), $urandom_range(1, n));
		stops.insert(stops.size(), n);
		for (int k = 0; k < hops; k++) begin
			src_q.insert(src_q.size(), stops[k]);
			dst_q.insert(dst_q.size(), stops[k + 1]);
		end
		for (int k = hops - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = src_q[k]; src_q[k] = src_q[j]; src_q[j] = t;
			t = dst_q[k]; dst_q[k] = dst_q[j]; dst_q[j] = t;
		end
		for (int k = 0; k < hops; k++) begin
			put(dpf_pkg::KIND_ADD, src_q[k], dst_q[k], $urandom_range(0, 4095));
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(3))
					0: put(dpf_pkg::KIND_ADD, $urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(0, 4095));
					1: put(dpf_pkg::KIND_ADD, $urandom_range(1, n), $urandom_range(1, n), 0);
					2: put(dpf_pkg::KIND_READ, $urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(0, 4095));
					default: put(dpf_pkg::KIND_SOLVE, $urandom_range(0, 2047),
						$urandom_range(0, 2047), $urandom_range(0, 4095));
				endcase
			end
		end
		put(dpf_pkg::KIND_SOLVE, $urandom_range(0, 2047), $urandom_range(0, 2047),
			$urandom_range(0, 4095));
		repeat ($urandom_range(3, 6)) begin
			if ($urandom_range(9) == 0)
				put(dpf_pkg::KIND_READ, $urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 4095));
			else
				put(dpf_pkg::KIND_READ, 0, 0, $urandom_range(0, hops + 1));
		end
	endtask

	initial begin
		int unsigned n;
		int unsigned cur_n;
		clk        = 1'b0;
		arst_n     = 1'b0;
		beats_sent = 0;
		graphs     = 0;
		cur_n      = 3;
		send_idle  = 14;
		recv_idle  = 82;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single node can never pass the degree check.
		put(dpf_pkg::KIND_SOLVE, 0, 0, 0);
		put(dpf_pkg::KIND_READ, 0, 0, 0);
		put(dpf_pkg::KIND_ADD, 1, 1, 0);
		put(dpf_pkg::KIND_SOLVE, 0, 0, 0);
		put(dpf_pkg::KIND_CLEAR, 0, 0, 0);
		set_nodes(0);
		put(dpf_pkg::KIND_ADD, 1, 1, 0);
		put(dpf_pkg::KIND_SOLVE, 0, 0, 0);
		set_nodes(dpf_pkg::MAX_NODES);
		put(dpf_pkg::KIND_ADD, 0, 5, 0);
		put(dpf_pkg::KIND_ADD, 5, 0, 0);
		put(dpf_pkg::KIND_ADD, 1025, 1, 0);
		put(dpf_pkg::KIND_ADD, 2047, 2047, 4095);
		put(dpf_pkg::KIND_ADD, 1, 1024, 0);
		put(dpf_pkg::KIND_SOLVE, 0, 0, 0);
		put(dpf_pkg::KIND_READ, 0, 0, 0);
		put(dpf_pkg::KIND_READ, 0, 0, 1);
		put(dpf_pkg::KIND_READ, 0, 0, 2);
		put(dpf_pkg::KIND_READ, 0, 0, 4095);
		// The found path stays readable while edges are added.
		put(dpf_pkg::KIND_ADD, 1024, 1, 0);
		put(dpf_pkg::KIND_READ, 0, 0, 1);
		put(dpf_pkg::KIND_SOLVE, 0, 0, 0);
		put(dpf_pkg::KIND_READ, 0, 0, 0);
		put(dpf_pkg::KIND_CLEAR, 0, 0, 0);
		// Edges to nodes beyond a reduced node count still take part in the walk.
		set_nodes(5);
		put(dpf_pkg::KIND_ADD, 1, 4, 0);
		put(dpf_pkg::KIND_ADD, 4, 3, 0);
		set_nodes(3);
		put(dpf_pkg::KIND_SOLVE, 0, 0, 0);
		put(dpf_pkg::KIND_READ, 0, 0, 1);
		put(dpf_pkg::KIND_READ, 0, 0, 2);

		while (beats_sent < 520) begin
			if (beats_sent > 360) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (beats_sent > 200) begin
				send_idle = 82;
				recv_idle = 14;
			end
			case ($urandom_range(7))
				0: n = dpf_pkg::MAX_NODES;
				1: n = 2;
				2: n = 3;
				default: n = $urandom_range(2, 12);
			endcase
			if ($urandom_range(19) == 0) n = 1;
			if (graphs % 4 == 0) begin
				set_nodes(n);
				cur_n = n;
			end
			if ($urandom_range(5) != 0) put(dpf_pkg::KIND_CLEAR, 0, 0, 0);
			random_graph((cur_n < 2) ? 2 : cur_n);
			graphs++;
		end

		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d beats over %0d random graphs plus directed cases.",
			beats_sent, graphs);
		$display("Solves that found a path: %0d, cycles used: %0d.", paths_found, cycles);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
